### design/fcrc_pkg.sv
// Shared types, constants and CRC helper for the frame CRC-16 appender.
package fcrc_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  MARK_DROP = 8'h00;
	localparam logic [7:0]  MARK_CRC = 8'h01;

	localparam logic [2:0]  IDLE_LIMIT_RST = 3'd3;

	localparam int CMD_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 4;

	localparam int ADDR_W = 3;
	localparam logic REG_IDLE_LIMIT = 1'b0;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_MARK,
		TAIL_CRC
	} tail_kind_t;

	typedef struct packed {
		logic       has_data;
		logic [7:0] data;
		logic       data_last;
		logic       frame_end;
		tail_kind_t tail;
		logic [7:0] marker;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(result_t);

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### design/fcrc_fifo.sv
// Small register FIFO used for the command queue and the result queue.
module fcrc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### design/fcrc_front.sv
// Front end: holds the two newest bytes, times idle gaps and issues commands.
module fcrc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               op,
	input  logic [7:0]         data_byte,
	input  logic [2:0]         idle_limit,
	output logic               cmd_push,
	output fcrc_pkg::cmd_t     cmd
);

	logic [7:0] older_q;
	logic [7:0] newest_q;
	logic [1:0] held_q;
	logic [2:0] idle_q;
	logic       active_q;

	logic held2;
	logic end_hit;
	logic is_byte;

	assign held2 = held_q[1];
	assign is_byte = (op == fcrc_pkg::OP_BYTE);
	assign end_hit = !is_byte && active_q && (idle_q >= idle_limit);

	always_comb begin
		cmd = '0;
		cmd.data = older_q;
		cmd.marker = newest_q;
		cmd.has_data = held2;
		cmd.tail = fcrc_pkg::TAIL_NONE;
		if (is_byte) begin
			cmd.data_last = 1'b0;
			cmd.frame_end = 1'b0;
		end else begin
			cmd.data_last = (newest_q == fcrc_pkg::MARK_DROP);
			cmd.frame_end = 1'b1;
			if (newest_q == fcrc_pkg::MARK_CRC) begin
				cmd.tail = fcrc_pkg::TAIL_CRC;
			end else if (newest_q != fcrc_pkg::MARK_DROP) begin
				cmd.tail = fcrc_pkg::TAIL_MARK;
			end
		end
	end

	// A frame end only issues a command when it produces at least one byte.
	assign cmd_push = accept && ((is_byte && held2) ||
		(end_hit && (held2 || (held_q != 2'd0 && newest_q != fcrc_pkg::MARK_DROP))));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= '0;
			newest_q <= '0;
			held_q <= '0;
			idle_q <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (is_byte) begin
				active_q <= 1'b1;
				idle_q <= '0;
				older_q <= newest_q;
				newest_q <= data_byte;
				held_q <= held2 ? 2'd2 : held_q + 1'b1;
			end else if (end_hit) begin
				older_q <= '0;
				newest_q <= '0;
				held_q <= '0;
				idle_q <= '0;
				active_q <= 1'b0;
			end else if (active_q) begin
				idle_q <= idle_q + 1'b1;
			end
		end
	end

endmodule

### design/fcrc_back.sv
// Back end: runs commands, folds data bytes into the CRC and emits result bytes.
module fcrc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  fcrc_pkg::cmd_t        cmd,
	output logic                  cmd_pop,
	input  logic                  res_full,
	output logic                  res_push,
	output fcrc_pkg::result_t     res
);

	typedef enum logic [1:0] {
		PH_DATA,
		PH_TAIL1,
		PH_TAIL2
	} phase_t;

	phase_t      phase_q;
	phase_t      cur;
	logic [15:0] crc_q;
	logic        done;
	logic        step;

	always_comb begin
		cur = phase_q;
		if (phase_q == PH_DATA && !cmd.has_data) begin
			cur = PH_TAIL1;
		end
	end

	always_comb begin
		res = '0;
		done = 1'b1;
		unique case (cur)
			PH_DATA: begin
				res.out_byte = cmd.data;
				res.last = cmd.data_last;
				done = (cmd.tail == fcrc_pkg::TAIL_NONE);
			end
			PH_TAIL1: begin
				if (cmd.tail == fcrc_pkg::TAIL_CRC) begin
					res.out_byte = crc_q[7:0];
					res.last = 1'b0;
					done = 1'b0;
				end else begin
					res.out_byte = cmd.marker;
					res.last = 1'b1;
				end
			end
			PH_TAIL2: begin
				res.out_byte = crc_q[15:8];
				res.last = 1'b1;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	assign step = cmd_valid && !res_full;
	assign res_push = step;
	assign cmd_pop = step && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
			crc_q <= fcrc_pkg::CRC_INIT;
		end else if (step) begin
			if (done && cmd.frame_end) begin
				crc_q <= fcrc_pkg::CRC_INIT;
			end else if (cur == PH_DATA) begin
				crc_q <= fcrc_pkg::crc_fold(crc_q, cmd.data);
			end
			if (done) begin
				phase_q <= PH_DATA;
			end else if (cur == PH_DATA) begin
				phase_q <= PH_TAIL1;
			end else begin
				phase_q <= PH_TAIL2;
			end
		end
	end

endmodule

### design/frame_crc16_appender.sv
// A byte pushed out of the two-byte hold passes through the command queue, then the result queue.
// Throughput: one input item per cycle while full is low; one result per back-end cycle while res_full is low.
// A frame end with a CRC marker yields up to 3 output bytes (one per cycle while res_full is low);
// the command queue absorbs this while input keeps flowing.
// Reset: asynchronous, clears frame state, queues and CRC; idle_limit returns to 3.
module frame_crc16_appender #(
	parameter int CMD_DEPTH = fcrc_pkg::CMD_DEPTH_DEF,
	parameter int OUT_DEPTH = fcrc_pkg::OUT_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        op,
	input  logic [7:0]                  data_byte,
	output logic                        empty,
	input  logic                        pop,
	output logic [7:0]                  out_byte,
	output logic                        last,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fcrc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [2:0] idle_limit_q;
	logic       cfg_wr;
	logic       accept;

	logic                       cmd_push;
	fcrc_pkg::cmd_t             cmd_in;
	logic [fcrc_pkg::CMD_W-1:0] cmd_rd;
	fcrc_pkg::cmd_t             cmd_out;
	logic                       cmd_empty;
	logic                       cmd_pop;

	logic                       res_full;
	logic                       res_push;
	fcrc_pkg::result_t          res_in;
	logic [fcrc_pkg::RES_W-1:0] res_rd;
	fcrc_pkg::result_t          res_out;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[fcrc_pkg::ADDR_W-1:2] == fcrc_pkg::REG_IDLE_LIMIT) ?
		{29'd0, idle_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= fcrc_pkg::IDLE_LIMIT_RST;
		end else if (cfg_wr && paddr[fcrc_pkg::ADDR_W-1:2] == fcrc_pkg::REG_IDLE_LIMIT) begin
			idle_limit_q <= pwdata[2:0];
		end
	end

	assign accept = push && !full;

	fcrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (op),
		.data_byte  (data_byte),
		.idle_limit (idle_limit_q),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	fcrc_fifo #(
		.WIDTH (fcrc_pkg::CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd),
		.empty   (cmd_empty)
	);

	assign cmd_out = cmd_rd;

	fcrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	fcrc_fifo #(
		.WIDTH (fcrc_pkg::RES_W),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_rd),
		.empty   (empty)
	);

	assign res_out = res_rd;
	assign out_byte = res_out.out_byte;
	assign last = res_out.last;

endmodule

### tb/tb.sv
// Self-checking testbench for the frame CRC-16 appender: register access and directed frames, then random traffic.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fcrc_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [ADDR_W-1:0] IDLE_LIMIT_ADDR = ADDR_W'(4 * REG_IDLE_LIMIT);

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic              op = OP_TICK;
	logic [7:0]        data_byte = 8'h00;
	logic              empty;
	logic              pop = 1'b0;
	logic [7:0]        out_byte;
	logic              last;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	int gap_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// Mirror of the frame state, kept in step with accepted transfers
	logic [2:0]  limit_m;
	logic [15:0] crc_m;
	logic [7:0]  older_m;
	logic [7:0]  newest_m;
	int          held_m;
	logic [2:0]  idle_m;
	logic        open_m;
	result_t     frame_bytes_due[$];
	result_t     want_out;

	frame_crc16_appender dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.op(op),
		.data_byte(data_byte),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		acc = crc ^ {8'h00, b};
		repeat (8) begin
			if (acc[0])
				acc = (acc >> 1) ^ CRC_POLY;
			else
				acc = acc >> 1;
		end
		return acc;
	endfunction

	function automatic void reset_frame_m();
		crc_m = CRC_INIT;
		older_m = 8'h00;
		newest_m = 8'h00;
		held_m = 0;
		idle_m = 3'd0;
		open_m = 1'b0;
	endfunction

	function automatic void expect_byte(input logic [7:0] b, input logic lst);
		result_t r;
		r.out_byte = b;
		r.last = lst;
		frame_bytes_due.push_back(r);
	endfunction

	function automatic void close_frame_m();
		logic [7:0] marker;
		marker = newest_m;
		if (held_m >= 2) begin
			crc_m = modbus_crc_byte(crc_m, older_m);
			expect_byte(older_m, marker == MARK_DROP);
		end
		if (held_m != 0) begin
			if (marker == MARK_CRC) begin
				expect_byte(crc_m[7:0], 1'b0);
				expect_byte(crc_m[15:8], 1'b1);
			end else if (marker != MARK_DROP) begin
				expect_byte(marker, 1'b1);
			end
		end
		reset_frame_m();
	endfunction

	function automatic void predict_frame_bytes(input logic o, input logic [7:0] b);
		if (o == OP_BYTE) begin
			open_m = 1'b1;
			idle_m = 3'd0;
			if (held_m >= 2) begin
				crc_m = modbus_crc_byte(crc_m, older_m);
				expect_byte(older_m, 1'b0);
			end else begin
				held_m++;
			end
			older_m = newest_m;
			newest_m = b;
		end else if (open_m) begin
			if (idle_m >= limit_m)
				close_frame_m();
			else
				idle_m = idle_m + 3'd1;
		end
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return MARK_DROP;
			1: return MARK_CRC;
			2: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	always @(posedge clk) pop <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (frame_bytes_due.size() == 0) begin
				$display("%0t unexpected transfer: expected none, actual out_byte %h last %b",
					$time, out_byte, last);
				mismatch_count++;
			end else begin
				want_out = frame_bytes_due.pop_front();
				if (out_byte !== want_out.out_byte) begin
					$display("%0t out_byte mismatch: expected %h actual %h",
						$time, want_out.out_byte, out_byte);
					mismatch_count++;
				end
				if (last !== want_out.last) begin
					$display("%0t last mismatch: expected %b actual %b",
						$time, want_out.last, last);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_item(input logic o, input logic [7:0] b);
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		op <= o;
		data_byte <= b;
		do @(posedge clk); while (full);
		predict_frame_bytes(o, b);
	endtask

	// Drop push, drain every expected byte, then let the pipeline go quiet
	task automatic settle_block();
		push <= 1'b0;
		@(posedge clk);
		while (frame_bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_transfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= IDLE_LIMIT_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_back_limit();
		logic [31:0] rd;
		apb_transfer(1'b0, 32'h0, rd);
		if (rd !== 32'(limit_m)) begin
			$display("%0t idle_limit read mismatch: expected %h actual %h", $time, 32'(limit_m), rd);
			mismatch_count++;
		end
	endtask

	task automatic set_idle_limit(input logic [2:0] value);
		logic [31:0] rd;
		apb_transfer(1'b1, 32'(value), rd);
		limit_m = value;
		read_back_limit();
	endtask

	task automatic test_register_access();
		read_back_limit();
		set_idle_limit(3'd7);
		set_idle_limit(3'd0);
		set_idle_limit(3'd5);
	endtask

	task automatic test_frame_markers();
		gap_pct = 0;
		stall_pct = 0;
		set_idle_limit(3'd0);
		// tick with no frame open is ignored
		send_item(OP_TICK, 8'hA5);
		// drop marker alone leaves an empty frame
		send_item(OP_BYTE, MARK_DROP);
		send_item(OP_TICK, 8'h00);
		// CRC marker alone sends the CRC of nothing
		send_item(OP_BYTE, MARK_CRC);
		send_item(OP_TICK, 8'hFF);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, MARK_DROP);
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, 8'h80);
		send_item(OP_BYTE, 8'h55);
		send_item(OP_BYTE, MARK_CRC);
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, 8'h12);
		send_item(OP_BYTE, 8'hAB);
		send_item(OP_TICK, 8'h7E);
		settle_block();
	endtask

	task automatic test_limit_lowered_midframe();
		set_idle_limit(3'd7);
		send_item(OP_BYTE, 8'h5A);
		send_item(OP_BYTE, 8'h3C);
		repeat (5) send_item(OP_TICK, 8'h00);
		settle_block();
		// idle count already past the new limit: the next tick closes the frame
		set_idle_limit(3'd2);
		send_item(OP_TICK, 8'h00);
		settle_block();
	endtask

	task automatic test_random_traffic(input int item_target, input int send_gap,
		input int recv_stall, input logic [2:0] limit);
		int sent;
		int len;
		int ticks;
		logic [7:0] marker;
		settle_block();
		set_idle_limit(limit);
		gap_pct = send_gap;
		stall_pct = recv_stall;
		sent = 0;
		while (sent < item_target) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
			for (int i = 1; i < len; i++) begin
				send_item(OP_BYTE, pick_byte());
				sent++;
				// quiet ticks short of the limit keep the frame open
				if ($urandom_range(3) == 0) begin
					ticks = $urandom_range(0, limit);
					repeat (ticks) send_item(OP_TICK, 8'($urandom));
					sent += ticks;
				end
			end
			case ($urandom_range(9))
				0, 1, 2, 3: marker = MARK_CRC;
				4, 5, 6: marker = MARK_DROP;
				default: marker = pick_byte();
			endcase
			send_item(OP_BYTE, marker);
			sent++;
			// a short tail lets the frame run on into the next one
			ticks = ($urandom_range(9) == 0) ? $urandom_range(0, limit) : limit + 1;
			repeat (ticks) send_item(OP_TICK, 8'($urandom));
			sent += ticks;
			repeat ($urandom_range(0, 2)) send_item(OP_TICK, 8'($urandom));
		end
		settle_block();
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t timeout", $time);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		reset_frame_m();
		limit_m = IDLE_LIMIT_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_frame_markers();
		test_limit_lowered_midframe();
		test_random_traffic(95, 0, 0, 3'd7);
		test_random_traffic(95, 86, 0, 3'd0);
		test_random_traffic(95, 0, 86, 3'($urandom_range(1, 6)));
		test_random_traffic(95, 31, 31, 3'($urandom_range(7)));
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
